@@ hdl/binary_search_table_macros.svh @@
// assertion helpers for the binary search table
`ifndef BINARY_SEARCH_TABLE_MACROS_SVH
`define BINARY_SEARCH_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define BST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("binary search table check failed");
`define BST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("binary search table check failed");
`else
`define BST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/bst_pkg.sv @@
package bst_pkg;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	localparam int KEY_W = 32;
	localparam int IDX_W = 7;
	localparam int CNT_W = 8;

	typedef struct packed {
		logic                    mode;
		logic [IDX_W-1:0]        write_index;
		logic signed [KEY_W-1:0] write_key;
		logic signed [KEY_W-1:0] search_key;
	} bst_in_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
	} bst_out_t;

endpackage

@@ hdl/bst_mem.sv @@
module bst_mem import bst_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [KEY_W-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic signed [KEY_W-1:0] rdata
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/bst_ctrl.sv @@
module bst_ctrl import bst_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int CW    = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [KEY_W-1:0] search_key,
	input  logic                    cfg_write,
	input  logic [CNT_W-1:0]        cfg_data,
	output logic                    busy,
	output logic [AW-1:0]           rd_addr,
	input  logic signed [KEY_W-1:0] rd_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output bst_out_t                out_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_CMP,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        entries_in_use_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]           low_q;
	logic [CW-1:0]           hi_q;
	logic [CW-1:0]           mid_q;
	bst_out_t                res_q;
	logic                    out_valid_q;
	bst_out_t                out_q;

	logic [CW-1:0] count;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic          key_eq;
	logic          key_lt;

	// count is entries_in_use clamped to the table depth
	always_comb begin
		if (32'(entries_in_use_q) > 32'(DEPTH)) begin
			count = CW'(DEPTH);
		end else begin
			count = CW'(entries_in_use_q);
		end
	end

	// hi_q is exclusive, so the probe is (low + hi - 1) / 2
	assign mid_sum = {1'b0, low_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
	assign mid     = mid_sum[CW:1];
	assign rd_addr = AW'(mid);

	// the one shared compare unit
	assign key_eq = (rd_data == key_q);
	assign key_lt = (key_q < rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= '0;
		end else if (cfg_write) begin
			entries_in_use_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_q       <= '0;
			low_q       <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// in S_DONE the output register is handled below
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q   <= search_key;
						low_q   <= '0;
						hi_q    <= count;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (low_q >= hi_q) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (key_eq) begin
						res_q.found    <= 1'b1;
						res_q.position <= IDX_W'(32'(mid_q));
						state_q        <= S_DONE;
					end else begin
						if (key_lt) begin
							hi_q <= mid_q;
						end else begin
							low_q <= mid_q + {{(CW-1){1'b0}}, 1'b1};
						end
						state_q <= S_PROBE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/binary_search_table.sv @@
// channel | direction | beat type | accepted when
// in      | in        | bst_in_t  | in_valid && !in_stall
// out     | out       | bst_out_t | out_valid && !out_stall
// cfg     | in        | 8 bits    | cfg_write
//
// a write beat goes straight into the table; a search repeats S_PROBE, which sets the
// table read address, and S_CMP, which feeds the registered table read into the one
// key compare, until a hit or an empty range sends it to S_DONE
// in_stall stays high from a search beat until its result sits in the output register
// a result waits there under out_stall while new beats are taken
// reset clears the sequencer, the output valid and entries_in_use; the table is not cleared
`include "binary_search_table_macros.svh"

module binary_search_table import bst_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bst_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output bst_out_t         out_data,
	input  logic             cfg_write,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic                    busy;
	logic                    in_take;
	logic                    start;
	logic                    wr_in_range;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [AW-1:0]           rd_addr;
	logic signed [KEY_W-1:0] rd_data;

	assign in_stall    = busy;
	assign in_take     = in_valid && !in_stall;
	assign start       = in_take && (in_data.mode == MODE_SEARCH);
	// writes past the table are dropped
	assign wr_in_range = 32'(in_data.write_index) < 32'(TABLE_DEPTH);
	assign mem_we      = in_take && (in_data.mode == MODE_WRITE) && wr_in_range;
	assign mem_waddr   = AW'(32'(in_data.write_index));

	bst_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (in_data.write_key),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bst_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.search_key (in_data.search_key),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.busy       (busy),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	`BST_ASSERT_NEXT(a_search_blocks, clk, arst_n, start, in_stall)
	`BST_ASSERT_SAME(a_result_after_busy, clk, arst_n, $rose(out_valid), $past(in_stall))
	`BST_ASSERT_SAME(a_miss_pos_zero, clk, arst_n, out_valid && !out_data.found, out_data.position == '0)

endmodule

@@ bench/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bst_pkg::*;

	localparam int TABLE_DEPTH = 128;
	localparam int SETTLE_CYCLES = 40;
	localparam int TARGET_BEATS = 600;
	localparam int REPORT_LIMIT = 10;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef enum logic {ROW_CONFIG, ROW_BEAT} row_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_plan_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             mode;
		logic [IDX_W-1:0] index;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
		logic             typed;
		logic             want_found;
		logic [IDX_W-1:0] want_pos;
	} row_t;

	// key field is the write key for writes and the search key for searches
	row_t plan [16] = '{
		'{ROW_CONFIG, MODE_WRITE,  7'd0,   32'h0,        8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   32'h0,        8'd0, 1'b1, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   KEY_MIN,      8'd0, 1'b1, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_WRITE,  7'd0,   KEY_MIN,      8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_WRITE,  7'd1,   32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_WRITE,  7'd2,   32'h0,        8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_WRITE,  7'd3,   32'd5,        8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_WRITE,  7'd127, KEY_MAX,      8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_CONFIG, MODE_WRITE,  7'd0,   32'h0,        8'd4, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   KEY_MIN,      8'd0, 1'b1, 1'b1, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   32'd5,        8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   32'd3,        8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   KEY_MAX,      8'd0, 1'b1, 1'b0, 7'd0},
		'{ROW_CONFIG, MODE_WRITE,  7'd0,   32'h0,        8'd1, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0, 7'd0},
		'{ROW_BEAT,   MODE_SEARCH, 7'd0,   KEY_MIN,      8'd0, 1'b0, 1'b0, 7'd0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	bst_in_t          in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	bst_out_t         out_data;
	logic             cfg_write = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;

	logic signed [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
	bit                      written [TABLE_DEPTH];
	int                      shadow_count = 0;
	bst_out_t                awaited_lookups [$];
	int                      mismatches = 0;
	int                      beats_sent = 0;
	int                      send_idle_pct = 0;
	int                      stall_pct = 0;

	binary_search_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// binary search over the shadow table, same probe order as the block
	function automatic bst_out_t lookup_key(logic signed [KEY_W-1:0] key);
		bst_out_t hit = '0;
		int lo = 0;
		int hi;
		int mid;
		hi = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (shadow_keys[mid] == key) begin
				hit.found = 1'b1;
				hit.position = mid[IDX_W-1:0];
				break;
			end else if (key < shadow_keys[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return hit;
	endfunction

	task automatic note_mismatch(string what, bst_out_t want, bst_out_t got);
		if (mismatches < REPORT_LIMIT) begin
			$display("%0t: %s: expected found=%0b position=%0d, got found=%0b position=%0d",
				$realtime, what, want.found, want.position, got.found, got.position);
		end
		mismatches++;
	endtask

	// called right after a falling edge; returns right after a falling edge
	task automatic push_beat(bst_in_t beat, bit typed, bst_out_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		if (beat.mode == MODE_SEARCH) begin
			awaited_lookups.push_back(typed ? want : lookup_key(beat.search_key));
		end else begin
			shadow_keys[beat.write_index] = beat.write_key;
			written[beat.write_index] = 1'b1;
		end
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_lookups.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_entry_count(logic [CNT_W-1:0] count);
		settle();
		cfg_write <= 1'b1;
		cfg_data <= count;
		@(posedge clk);
		shadow_count = int'(count);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : watch_results
		bst_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_lookups.size() == 0) begin
				note_mismatch("result with no search pending", '0, out_data);
			end else begin
				want = awaited_lookups.pop_front();
				if (out_data.found !== want.found || out_data.position !== want.position) begin
					note_mismatch("search result", want, out_data);
				end
			end
		end
	end

	initial begin : stimulus
		bst_in_t                 beat;
		bst_out_t                want;
		int                      span;
		int                      searches;
		int                      roll;
		int                      pick;
		bit                      small_keys;
		bit                      reload;
		logic [CNT_W-1:0]        count;
		logic signed [KEY_W-1:0] key;
		int                      sorted_keys [$];

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CONFIG) begin
				set_entry_count(plan[i].count);
			end else begin
				beat.mode = plan[i].mode;
				beat.write_index = plan[i].index;
				beat.write_key = plan[i].key;
				beat.search_key = plan[i].key;
				want.found = plan[i].want_found;
				want.position = plan[i].want_pos;
				push_beat(beat, plan[i].typed, want);
			end
		end

		for (int p = 0; beats_sent < TARGET_BEATS || p < 8; p++) begin
			case (p)
				0: count = 8'd128;
				1: count = 8'd255;
				2: count = 8'd2;
				default: count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 255))
					: CNT_W'($urandom_range(0, 24));
			endcase
			send_idle_pct = 0;
			stall_pct = 0;
			set_entry_count(count);
			case (idle_plan_t'(p % 4))
				IDLE_SENDER:   send_idle_pct = 46;
				IDLE_RECEIVER: stall_pct = 46;
				IDLE_BOTH: begin
					send_idle_pct = 34;
					stall_pct = 34;
				end
				default: ;
			endcase
			span = (int'(count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);

			// a search may only probe entries that were written
			reload = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < span; i++) begin
				if (!written[i]) reload = 1'b1;
			end
			if (reload) begin
				sorted_keys.delete();
				small_keys = ($urandom_range(0, 2) == 0);
				for (int i = 0; i < span; i++) begin
					sorted_keys.push_back(small_keys ? int'($urandom_range(0, 60)) - 30
						: int'($urandom));
				end
				sorted_keys.sort();
				for (int i = 0; i < span; i++) begin
					beat.mode = MODE_WRITE;
					beat.write_index = i[IDX_W-1:0];
					beat.write_key = sorted_keys[i];
					beat.search_key = $urandom;
					push_beat(beat, 1'b0, '0);
				end
			end

			searches = 25 + $urandom_range(0, 20);
			for (int s = 0; s < searches; s++) begin
				if ((p == 2 && s == 10) || $urandom_range(0, 49) == 0) begin
					in_valid <= 1'b0;
					while (awaited_lookups.size() != 0) @(negedge clk);
				end
				roll = $urandom_range(0, 99);
				pick = (span > 0) ? $urandom_range(0, span - 1) : 0;
				beat.write_index = IDX_W'($urandom);
				beat.write_key = $urandom;
				beat.search_key = $urandom;
				if (roll < 8) begin
					// stray write, may leave the table unsorted
					beat.mode = MODE_WRITE;
				end else begin
					beat.mode = MODE_SEARCH;
					if (span > 0 && roll < 55) begin
						beat.search_key = shadow_keys[pick];
					end else if (span > 0 && roll < 70) begin
						key = shadow_keys[pick];
						beat.search_key = $urandom_range(0, 1) ? key + 1 : key - 1;
					end else if (roll < 82) begin
						case ($urandom_range(0, 2))
							0: beat.search_key = KEY_MIN;
							1: beat.search_key = KEY_MAX;
							default: beat.search_key = '0;
						endcase
					end
				end
				push_beat(beat, 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0 && awaited_lookups.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
